// ----- design/mtmf_pkg.sv -----
// Package for the multichannel trimmed-mean filter.
// Holds shared widths, action codes and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package mtmf_pkg;

  localparam int MTMF_CHANNELS_DEF = 4;
  localparam int MTMF_WINDOW_DEF   = 8;

  localparam int VAL_W     = 24;
  localparam int VAL_MAX   = 8388607;
  localparam int VAL_MIN   = -8388608;
  localparam int CHAN_W    = 2;
  localparam int ACT_W     = 2;
  localparam int IN_USER_W  = ACT_W + CHAN_W + 1;
  localparam int OUT_USER_W = CHAN_W + 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH      = 2'd0,
    ACT_NOT_READY = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef struct packed {
    logic latch;
    logic apply;
    logic write;
    logic rd_step;
    logic prep;
    logic div_step;
    logic store;
    logic emit;
  } mtmf_cmd_t;

  typedef struct packed {
    logic push_ok;
    logic rd_done;
    logic div_done;
    logic out_free;
  } mtmf_stat_t;

endpackage

// ----- design/mtmf_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module mtmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/mtmf_ctrl.sv -----
// Controller state machine of the trimmed-mean filter.
// Depends on mtmf_pkg; drives the datapath by command struct and reads its status struct.
`timescale 1ns / 1ps

module mtmf_ctrl
  import mtmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  mtmf_stat_t stat,
  output mtmf_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_WRITE  = 8'b0000_0100,
    S_READ   = 8'b0000_1000,
    S_PREP   = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_STORE  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.push_ok) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_step = 1'b1;
        if (stat.rd_done) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_STORE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/mtmf_datapath.sv -----
// Datapath of the trimmed-mean filter: per-channel state, window RAM, window walk,
// restoring divider and output register. Depends on mtmf_pkg and mtmf_ram.
`timescale 1ns / 1ps

module mtmf_datapath
  import mtmf_pkg::*;
#(
  parameter int CHANNELS = MTMF_CHANNELS_DEF,
  parameter int WINDOW   = MTMF_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic [VAL_W-1:0]      in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic [VAL_W-1:0]      out_tdata,
  input  mtmf_cmd_t             cmd,
  output mtmf_stat_t            stat
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = VAL_W + CW;
  localparam int DCW   = $clog2(SUM_W + 1);
  localparam logic signed [SUM_W:0] Q_MAX = (SUM_W + 1)'(VAL_MAX);
  localparam logic signed [SUM_W:0] Q_MIN = (SUM_W + 1)'(VAL_MIN);

  // Latched input word.
  action_t           act_r;
  logic [CHAN_W-1:0] chan_r;
  logic              rdy_r;
  logic [VAL_W-1:0]  samp_r;

  // Per-channel state.
  logic [PW-1:0]    pos_r  [CHANNELS];
  logic [CW-1:0]    fill_r [CHANNELS];
  logic [VAL_W-1:0] filt_r [CHANNELS];
  logic [CHANNELS-1:0] vld_r;

  // Window walk and divider.
  logic [CW-1:0]              rd_cnt_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [VAL_W-1:0]    lo_r, hi_r;
  logic                       neg_r;
  logic [SUM_W-1:0]           dq_r;
  logic [CW:0]                rem_r;
  logic [CW-1:0]              dvs_r;
  logic [DCW-1:0]             div_cnt_r;

  logic                  out_valid_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic [VAL_W-1:0]      out_data_r;

  logic [4:0]          ch_ext;
  logic [CH_W-1:0]     ch_idx;
  logic                ch_ok;
  logic [CW-1:0]       n_cur;
  logic [PW-1:0]       pos_cur;
  logic [AW-1:0]       base;
  logic                ram_re;
  logic [VAL_W-1:0]    ram_rdata;
  logic signed [VAL_W-1:0] rd_val;
  logic                trim;
  logic signed [SUM_W-1:0] num;
  logic [CW:0]         rem_sh;
  logic                q_bit;
  logic signed [SUM_W:0] q_mag, qs;
  logic [VAL_W-1:0]    q_sat;
  logic                fv;

  assign ch_ext  = {3'b000, chan_r};
  assign ch_idx  = ch_ext[CH_W-1:0];
  assign ch_ok   = ch_ext < 5'(CHANNELS);
  assign n_cur   = fill_r[ch_idx];
  assign pos_cur = pos_r[ch_idx];
  assign base    = AW'(ch_idx * WINDOW);
  assign ram_re  = cmd.rd_step && (rd_cnt_r < n_cur);
  assign rd_val  = signed'(ram_rdata);
  assign trim    = 32'(n_cur) > 32'd2;
  assign num     = trim ? (sum_r - SUM_W'(lo_r) - SUM_W'(hi_r)) : sum_r;
  assign rem_sh  = {rem_r[CW-1:0], dq_r[SUM_W-1]};
  assign q_bit   = rem_sh >= {1'b0, dvs_r};
  assign q_mag   = signed'({1'b0, dq_r});
  assign qs      = neg_r ? -q_mag : q_mag;
  assign q_sat   = (qs > Q_MAX) ? VAL_W'(Q_MAX) : (qs < Q_MIN) ? VAL_W'(Q_MIN) : qs[VAL_W-1:0];
  assign fv      = ch_ok && vld_r[ch_idx];

  assign stat.push_ok  = ch_ok && (act_r == ACT_PUSH) && rdy_r;
  assign stat.rd_done  = rd_cnt_r == n_cur;
  assign stat.div_done = div_cnt_r == '0;
  assign stat.out_free = !out_valid_r || out_tready;

  mtmf_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.write),
    .waddr(base + AW'(pos_cur)),
    .wdata(samp_r),
    .re   (ram_re),
    .raddr(base + AW'(rd_cnt_r[PW-1:0])),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i]  <= '0;
        fill_r[i] <= '0;
        filt_r[i] <= '0;
      end
    end else begin
      if (cmd.apply) begin
        if (act_r == ACT_CLEAR) begin
          vld_r <= '0;
          for (int i = 0; i < CHANNELS; i++) begin
            pos_r[i]  <= '0;
            fill_r[i] <= '0;
            filt_r[i] <= '0;
          end
        end else if (ch_ok && ((act_r == ACT_NOT_READY) || (act_r == ACT_PUSH))) begin
          vld_r[ch_idx]  <= 1'b0;
          filt_r[ch_idx] <= '0;
        end
      end
      if (cmd.write) begin
        pos_r[ch_idx] <= (32'(pos_cur) == WINDOW - 1) ? '0 : pos_cur + 1'b1;
        if (32'(n_cur) < WINDOW) begin
          fill_r[ch_idx] <= n_cur + 1'b1;
        end
      end
      if (cmd.store) begin
        filt_r[ch_idx] <= q_sat;
        vld_r[ch_idx]  <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= action_t'(in_tuser[ACT_W-1:0]);
      chan_r <= in_tuser[ACT_W+CHAN_W-1:ACT_W];
      rdy_r  <= in_tuser[IN_USER_W-1];
      samp_r <= in_tdata;
    end
    if (cmd.write) begin
      rd_cnt_r <= '0;
    end else if (cmd.rd_step && !stat.rd_done) begin
      rd_cnt_r <= rd_cnt_r + 1'b1;
    end
    if (cmd.rd_step && (rd_cnt_r != '0)) begin
      if (rd_cnt_r == CW'(1)) begin
        sum_r <= SUM_W'(rd_val);
        lo_r  <= rd_val;
        hi_r  <= rd_val;
      end else begin
        sum_r <= sum_r + SUM_W'(rd_val);
        if (rd_val < lo_r) begin
          lo_r <= rd_val;
        end
        if (rd_val > hi_r) begin
          hi_r <= rd_val;
        end
      end
    end
    if (cmd.prep) begin
      neg_r     <= num[SUM_W-1];
      dq_r      <= num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
      rem_r     <= '0;
      dvs_r     <= trim ? CW'(32'(n_cur) - 32'd2) : n_cur;
      div_cnt_r <= DCW'(SUM_W);
    end
    if (cmd.div_step) begin
      rem_r     <= q_bit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      dq_r      <= {dq_r[SUM_W-2:0], q_bit};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (cmd.emit) begin
      out_user_r <= {&vld_r, fv, chan_r};
      out_data_r <= fv ? filt_r[ch_idx] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- design/multichannel_trimmed_mean_filter.sv -----
// Top level of the multichannel moving-window trimmed-mean filter.
// Depends on mtmf_pkg, mtmf_ctrl and mtmf_datapath.
`timescale 1ns / 1ps

// One input word gives exactly one output word. Words are handled one at a time:
// clear, not-ready and ignored words go from acceptance through the decode state to
// the output register; a pushed sample first walks the channel's filled entries of
// the window RAM, one entry per cycle through its single read port, and then runs
// the restoring divider, which produces one quotient bit per cycle over
// 24 + clog2(WINDOW+1) bits. The output register lets a finished result wait while
// the next input word is taken.

module multichannel_trimmed_mean_filter
  import mtmf_pkg::*;
#(
  parameter int CHANNELS = MTMF_CHANNELS_DEF,
  parameter int WINDOW   = MTMF_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Bits from low: action[1:0], channel[3:2], sample_ready[4].
  input  logic [IN_USER_W-1:0]  in_tuser,
  // Bits from low: sample_value[23:0].
  input  logic [VAL_W-1:0]      in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Bits from low: out_channel[1:0], filtered_valid[2], all_ready[3].
  output logic [OUT_USER_W-1:0] out_tuser,
  // Bits from low: filtered_value[23:0].
  output logic [VAL_W-1:0]      out_tdata
);

  mtmf_cmd_t  cmd;
  mtmf_stat_t stat;

  mtmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtmf_datapath #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- design/mtmf_checker.sv -----
// Port-level checker for the trimmed-mean filter, bound to the top level.
// Depends on mtmf_pkg and multichannel_trimmed_mean_filter.
`timescale 1ns / 1ps

module mtmf_checker
  import mtmf_pkg::*;
#(
  parameter int CHANNELS = MTMF_CHANNELS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic [VAL_W-1:0]      out_tdata
);

  logic [4:0] out_ch_ext;
  assign out_ch_ext = {3'b000, out_tuser[CHAN_W-1:0]};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the word was processed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[CHAN_W] |-> out_tdata == '0)
    else $error("invalid channel reported a nonzero value");

  a_all_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[CHAN_W+1] && (out_ch_ext < 5'(CHANNELS)) |-> out_tuser[CHAN_W])
    else $error("all channels ready but reported channel invalid");

endmodule

bind multichannel_trimmed_mean_filter mtmf_checker #(.CHANNELS(CHANNELS)) u_mtmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tuser (out_tuser),
  .out_tdata (out_tdata)
);

// ----- test/mtmf_filter_checker.sv -----
// Checker for the multichannel trimmed-mean filter: predicts one output word per accepted
// input word and compares each output word against the oldest prediction.
// Depends on mtmf_pkg.
`timescale 1ns / 1ps

module mtmf_filter_checker
  import mtmf_pkg::*;
#(
  parameter int CHANNELS = MTMF_CHANNELS_DEF,
  parameter int WINDOW   = MTMF_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic [VAL_W-1:0]      in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic [VAL_W-1:0]      out_tdata,
  output int                    mismatches,
  output int                    words_due
);

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [VAL_W-1:0]  value;
    logic              valid;
    logic              every_valid;
  } filter_word_t;

  filter_word_t            due_q[$];
  logic signed [VAL_W-1:0] samples [CHANNELS][WINDOW];
  int unsigned             wr_pos [CHANNELS];
  int unsigned             fill [CHANNELS];
  logic [VAL_W-1:0]        level [CHANNELS];
  logic                    level_ok [CHANNELS];

  function automatic logic [VAL_W-1:0] trimmed_mean(int ch);
    longint total;
    longint lo;
    longint hi;
    longint q;
    longint v;
    int     n;
    n = fill[ch];
    if (n == 0) return '0;
    total = 0;
    lo = samples[ch][0];
    hi = lo;
    for (int i = 0; i < n; i++) begin
      v = samples[ch][i];
      total += v;
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    end
    if (n <= 2) q = total / n;
    else q = (total - lo - hi) / (n - 2);
    if (q > VAL_MAX) q = VAL_MAX;
    if (q < VAL_MIN) q = VAL_MIN;
    return q[VAL_W-1:0];
  endfunction

  function automatic void clear_filters();
    for (int c = 0; c < CHANNELS; c++) begin
      wr_pos[c] = 0;
      fill[c] = 0;
      level[c] = '0;
      level_ok[c] = 1'b0;
    end
  endfunction

  function automatic void predict_word(logic [IN_USER_W-1:0] user, logic [VAL_W-1:0] data);
    action_t      act;
    int           ch;
    logic         rdy;
    int unsigned  pos;
    filter_word_t w;
    act = action_t'(user[ACT_W-1:0]);
    ch = int'(user[ACT_W +: CHAN_W]);
    rdy = user[ACT_W+CHAN_W];
    if (act == ACT_CLEAR) begin
      clear_filters();
    end else if (ch < CHANNELS && (act == ACT_NOT_READY || (act == ACT_PUSH && !rdy))) begin
      level_ok[ch] = 1'b0;
      level[ch] = '0;
    end else if (ch < CHANNELS && act == ACT_PUSH) begin
      pos = wr_pos[ch] % WINDOW;
      samples[ch][pos] = data;
      wr_pos[ch] = (pos + 1) % WINDOW;
      if (fill[ch] < WINDOW) fill[ch]++;
      level[ch] = trimmed_mean(ch);
      level_ok[ch] = 1'b1;
    end
    w.chan = CHAN_W'(ch);
    w.every_valid = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!level_ok[c]) w.every_valid = 1'b0;
    end
    if (ch < CHANNELS && level_ok[ch]) begin
      w.value = level[ch];
      w.valid = 1'b1;
    end else begin
      w.value = '0;
      w.valid = 1'b0;
    end
    due_q.push_back(w);
  endfunction

  function automatic void check_word(logic [OUT_USER_W-1:0] user, logic [VAL_W-1:0] data);
    filter_word_t w;
    if (due_q.size() == 0) begin
      $error("output word with nothing pending: out_channel %0d", user[CHAN_W-1:0]);
      mismatches++;
      return;
    end
    w = due_q.pop_front();
    if (user[CHAN_W-1:0] !== w.chan) begin
      $error("out_channel mismatch: expected %0d, actual %0d", w.chan, user[CHAN_W-1:0]);
      mismatches++;
    end
    if (data !== w.value) begin
      $error("filtered_value mismatch: expected %0d, actual %0d",
             $signed(w.value), $signed(data));
      mismatches++;
    end
    if (user[CHAN_W] !== w.valid) begin
      $error("filtered_valid mismatch: expected %0b, actual %0b", w.valid, user[CHAN_W]);
      mismatches++;
    end
    if (user[CHAN_W+1] !== w.every_valid) begin
      $error("all_ready mismatch: expected %0b, actual %0b", w.every_valid, user[CHAN_W+1]);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      due_q.delete();
      for (int c = 0; c < CHANNELS; c++) begin
        for (int i = 0; i < WINDOW; i++) begin
          samples[c][i] = '0;
        end
      end
      clear_filters();
    end else begin
      if (out_tvalid && out_tready) check_word(out_tuser, out_tdata);
      if (in_tvalid && in_tready) predict_word(in_tuser, in_tdata);
    end
    words_due <= due_q.size();
  end

endmodule

// ----- test/tb_multichannel_trimmed_mean_filter.sv -----
// Testbench top for the multichannel trimmed-mean filter: drives directed and random words
// with random idling on both channels and reports the verdict.
// Depends on mtmf_pkg, multichannel_trimmed_mean_filter and mtmf_filter_checker.
`timescale 1ns / 1ps

module tb_multichannel_trimmed_mean_filter
  import mtmf_pkg::*;
();

  localparam int CHANNELS = MTMF_CHANNELS_DEF;
  localparam int WINDOW   = MTMF_WINDOW_DEF;
  localparam logic [VAL_W-1:0] SAMPLE_MAX = VAL_W'(VAL_MAX);
  localparam logic [VAL_W-1:0] SAMPLE_MIN = VAL_W'(VAL_MIN);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_USER_W-1:0]  in_tuser;
  logic [VAL_W-1:0]      in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_USER_W-1:0] out_tuser;
  logic [VAL_W-1:0]      out_tdata;
  int                    mismatches;
  int                    words_due;
  bit                    calm = 1'b0;
  int                    out_hold = 0;

  always #2 clk = ~clk;

  multichannel_trimmed_mean_filter #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_top (.*);

  mtmf_filter_checker #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) u_checker (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [VAL_W-1:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 35) v = $urandom;
    else if (r < 65) v = $urandom_range(4000) - 2000;
    else if (r < 80) v = r[0] ? VAL_MAX : VAL_MIN;
    else v = r[0] ? VAL_MAX - $urandom_range(255) : VAL_MIN + $urandom_range(255);
    return v[VAL_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_tready <= 1'b1;
      out_hold <= pick_gap();
    end
  end

  task automatic send_word(action_t act, logic [CHAN_W-1:0] ch, logic rdy,
                           logic [VAL_W-1:0] sample);
    int gap;
    in_tuser <= {rdy, ch, act};
    in_tdata <= sample;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int                r;
    logic [CHAN_W-1:0] ch;
    r = $urandom_range(99);
    ch = CHAN_W'($urandom_range((1 << CHAN_W) - 1));
    if (r < 72) send_word(ACT_PUSH, ch, 1'b1, pick_sample());
    else if (r < 80) send_word(ACT_PUSH, ch, 1'b0, pick_sample());
    else if (r < 90) send_word(ACT_NOT_READY, ch, 1'($urandom_range(1)), pick_sample());
    else if (r < 97) send_word(ACT_NONE, ch, 1'($urandom_range(1)), pick_sample());
    else send_word(ACT_CLEAR, ch, 1'($urandom_range(1)), pick_sample());
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Extremes on one channel, then a trimmed mean over three samples.
    send_word(ACT_PUSH, 2'd0, 1'b1, SAMPLE_MAX);
    send_word(ACT_PUSH, 2'd0, 1'b1, SAMPLE_MAX);
    send_word(ACT_PUSH, 2'd0, 1'b1, SAMPLE_MIN);
    // Plain mean of two with an odd negative sum truncates toward zero.
    send_word(ACT_PUSH, 2'd1, 1'b1, SAMPLE_MIN);
    send_word(ACT_PUSH, 2'd1, 1'b1, -24'sd3);
    send_word(ACT_PUSH, 2'd2, 1'b1, 24'd0);
    send_word(ACT_PUSH, 2'd3, 1'b1, 24'd1);
    send_word(ACT_NONE, 2'd2, 1'b1, 24'hFFFFFF);
    send_word(ACT_PUSH, 2'd3, 1'b0, 24'h123456);
    send_word(ACT_NOT_READY, 2'd1, 1'b1, 24'hABCDEF);
    // The window survives a not-ready word.
    send_word(ACT_PUSH, 2'd1, 1'b1, 24'd5);
    send_word(ACT_PUSH, 2'd3, 1'b1, -24'sd7);
    send_word(ACT_CLEAR, 2'd2, 1'b0, 24'h000000);
    send_word(ACT_PUSH, 2'd2, 1'b1, 24'h555555);
    // Fill channel 0 again past the window length so the ring wraps.
    for (int i = 0; i < WINDOW + 2; i++) begin
      send_word(ACT_PUSH, 2'd0, 1'b1, (i % 2) ? 24'hAAAAAA : VAL_W'(24'h555555 + i));
    end
    send_word(ACT_CLEAR, 2'd3, 1'b1, 24'hFFFFFF);

    for (int i = 0; i < 600; i++) send_random();
    wait_drained();
    calm = 1'b1;
    for (int i = 0; i < 250; i++) send_random();
    calm = 1'b0;
    for (int i = 0; i < 550; i++) send_random();

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
